// ===== hw/rtl/websocket_masked_frame_encoder_unit_defines.svh =====
// assertion macros for the websocket masked frame encoder
// no dependencies; the assertion bodies are left empty when SYNTHESIS is defined
`ifndef WEBSOCKET_MASKED_FRAME_ENCODER_UNIT_DEFINES_SVH
`define WEBSOCKET_MASKED_FRAME_ENCODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define WSFE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wsfe same-cycle check failed");
// next-cycle implication, disabled during reset
`define WSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wsfe next-cycle check failed");
`else
`define WSFE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define WSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/wsfe_pkg.sv =====
// shared types and constants of the websocket masked frame encoder
// no dependencies; used by the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package wsfe_pkg;

	// frame opcodes with special handling
	localparam logic [3:0] OPC_CONT  = 4'd0;
	localparam logic [3:0] OPC_CLOSE = 4'd8;
	localparam logic [3:0] OPC_PING  = 4'd9;
	localparam logic [3:0] OPC_PONG  = 4'd10;

	// item kinds
	localparam logic OP_START = 1'b0;
	localparam logic OP_BYTE  = 1'b1;

	// result error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OPCODE   = 2'd1;
	localparam logic [1:0] ERR_NO_FRAME = 2'd2;

	// length encoding
	localparam logic [31:0] LEN_SHORT_MAX = 32'd125;
	localparam logic [31:0] LEN_MID_MAX   = 32'h0000_ffff;
	localparam logic [6:0]  LEN_MID_CODE  = 7'd126;
	localparam logic [6:0]  LEN_LONG_CODE = 7'd127;
	localparam logic [7:0]  HIGH_BIT      = 8'h80;
	localparam logic [15:0] STATUS_NORMAL = 16'h03e8;

	// header layout: first key byte position for each length form
	localparam logic [3:0] KEY_START_SHORT = 4'd2;
	localparam logic [3:0] KEY_START_MID   = 4'd4;
	localparam logic [3:0] KEY_START_LONG  = 4'd10;

	typedef enum logic [1:0] {
		FORM_SHORT,
		FORM_MID,
		FORM_LONG
	} form_t;

	typedef enum logic {
		ST_IDLE,
		ST_HEADER
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take_item;
		logic emit_hdr;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic item_is_hdr;
		logic hdr_final;
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wsfe_ctrl.sv =====
// controller of the websocket masked frame encoder: idle / header sequencing
// depends on wsfe_pkg for the state type and the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module wsfe_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	input  wsfe_pkg::sts_t sts,
	output wsfe_pkg::cmd_t cmd
);
	import wsfe_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	// input beat is taken only when idle and the output register can be loaded
	assign in_stall = !((state_q == ST_IDLE) && sts.out_free);
	assign accept   = in_valid && !in_stall;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && sts.item_is_hdr) begin
					state_nxt = ST_HEADER;
				end
			end
			ST_HEADER: begin
				if (sts.out_free && sts.hdr_final) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.take_item = accept;
			ST_HEADER: cmd.emit_hdr  = sts.out_free;
			default:   cmd = '0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/wsfe_dp.sv =====
// datapath of the websocket masked frame encoder: frame state, header bytes, output register
// depends on wsfe_pkg for codes, length constants and the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module wsfe_dp (
	input  wire            clk,
	input  wire            arst_n,
	input  wsfe_pkg::cmd_t cmd,
	output wsfe_pkg::sts_t sts,
	input  wire            op,
	input  wire  [3:0]     frame_type,
	input  wire  [31:0]    payload_length,
	input  wire  [31:0]    mask_key,
	input  wire  [7:0]     payload_byte,
	output logic           out_valid,
	input  wire            out_stall,
	output logic [7:0]     out_byte,
	output logic           last,
	output logic [1:0]     error_code
);
	import wsfe_pkg::*;

	// byte idx of a 32-bit word, byte 0 in bits 31..24
	function automatic logic [7:0] byte_of(input logic [31:0] word, input logic [1:0] idx);
		logic [4:0] sh;
		sh = {~idx, 3'b000};
		return word[sh +: 8];
	endfunction

	// frame state
	logic        in_frame_q;
	logic [31:0] bytes_left_q;
	logic [31:0] key_store_q;
	logic [1:0]  key_index_q;

	// header sequencing
	logic [3:0]  step_q;
	logic [31:0] len_q;
	form_t       form_q;
	logic        close_q;
	logic        len_zero_q;

	// output register
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;
	logic [1:0]  error_q;

	// item decode
	logic        is_reject;
	logic        is_close;
	logic        is_hdr;
	logic [31:0] len_eff;
	logic        len_eff_zero;
	form_t       form_in;

	always_comb begin
		is_reject = (frame_type == OPC_CONT) || (frame_type == OPC_PING);
		is_close  = (frame_type == OPC_CLOSE);
		is_hdr    = (op == OP_START) && !is_reject;
		if (frame_type == OPC_PONG) begin
			len_eff = '0;
		end else if (is_close) begin
			len_eff = 32'd2;
		end else begin
			len_eff = payload_length;
		end
		len_eff_zero = (len_eff == '0);
		if (len_eff <= LEN_SHORT_MAX) begin
			form_in = FORM_SHORT;
		end else if (len_eff <= LEN_MID_MAX) begin
			form_in = FORM_MID;
		end else begin
			form_in = FORM_LONG;
		end
	end

	// result of a single-beat item or the first header byte
	logic [7:0] first_byte;
	logic       first_last;
	logic [1:0] first_err;
	logic       bytes_last;

	assign bytes_last = (bytes_left_q == 32'd1);

	always_comb begin
		first_byte = '0;
		first_last = 1'b1;
		first_err  = ERR_NONE;
		if (op == OP_BYTE) begin
			if (in_frame_q) begin
				first_byte = payload_byte ^ byte_of(key_store_q, key_index_q);
				first_last = bytes_last;
			end else begin
				first_err = ERR_NO_FRAME;
			end
		end else if (is_reject) begin
			first_err = ERR_OPCODE;
		end else begin
			first_byte = HIGH_BIT | {4'b0000, frame_type};
			first_last = 1'b0;
		end
	end

	// header byte at step_q
	logic [3:0] key_start;
	logic [3:0] key_ofs;
	logic [3:0] key_end;
	logic [1:0] len_sel;
	logic [7:0] hdr_byte;
	logic       hdr_last;
	logic       hdr_final;

	always_comb begin
		case (form_q)
			FORM_MID:  key_start = KEY_START_MID;
			FORM_LONG: key_start = KEY_START_LONG;
			default:   key_start = KEY_START_SHORT;
		endcase
		key_ofs = step_q - key_start;
		key_end = key_start + 4'd3;
		len_sel = step_q[1:0] - 2'd2;
		hdr_byte = '0;
		if (step_q > key_end) begin
			// close status code after the key
			if (key_ofs[0]) begin
				hdr_byte = STATUS_NORMAL[7:0] ^ byte_of(key_store_q, 2'd1);
			end else begin
				hdr_byte = STATUS_NORMAL[15:8] ^ byte_of(key_store_q, 2'd0);
			end
		end else if (step_q >= key_start) begin
			hdr_byte = byte_of(key_store_q, key_ofs[1:0]);
		end else begin
			case (form_q)
				FORM_MID: begin
					if (step_q == 4'd1) begin
						hdr_byte = HIGH_BIT | {1'b0, LEN_MID_CODE};
					end else if (step_q == 4'd2) begin
						hdr_byte = len_q[15:8];
					end else begin
						hdr_byte = len_q[7:0];
					end
				end
				FORM_LONG: begin
					if (step_q == 4'd1) begin
						hdr_byte = HIGH_BIT | {1'b0, LEN_LONG_CODE};
					end else if (step_q >= 4'd6) begin
						hdr_byte = byte_of(len_q, len_sel);
					end else begin
						hdr_byte = '0;
					end
				end
				default: hdr_byte = HIGH_BIT | {1'b0, len_q[6:0]};
			endcase
		end
		if (close_q) begin
			hdr_final = (step_q == key_end + 4'd2);
			hdr_last  = hdr_final;
		end else begin
			hdr_final = (step_q == key_end);
			hdr_last  = hdr_final && len_zero_q;
		end
	end

	// status
	assign sts.out_free    = !out_valid_q || !out_stall;
	assign sts.item_is_hdr = is_hdr;
	assign sts.hdr_final   = hdr_final;

	// frame state update on item beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			bytes_left_q <= '0;
			key_store_q  <= '0;
			key_index_q  <= '0;
		end else if (cmd.take_item) begin
			if (op == OP_BYTE) begin
				if (in_frame_q) begin
					key_index_q  <= key_index_q + 2'd1;
					bytes_left_q <= bytes_left_q - 32'd1;
					if (bytes_last) begin
						in_frame_q <= 1'b0;
					end
				end
			end else if (is_reject) begin
				in_frame_q <= 1'b0;
			end else begin
				key_store_q <= mask_key;
				key_index_q <= '0;
				if (is_close || len_eff_zero) begin
					in_frame_q   <= 1'b0;
					bytes_left_q <= '0;
				end else begin
					in_frame_q   <= 1'b1;
					bytes_left_q <= len_eff;
				end
			end
		end
	end

	// header step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.take_item) begin
			step_q <= 4'd1;
		end else if (cmd.emit_hdr) begin
			step_q <= step_q + 4'd1;
		end
	end

	// header fields latched at frame start
	always_ff @(posedge clk) begin
		if (cmd.take_item && is_hdr) begin
			len_q      <= len_eff;
			form_q     <= form_in;
			close_q    <= is_close;
			len_zero_q <= len_eff_zero;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.take_item || cmd.emit_hdr) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			out_byte_q <= first_byte;
			last_q     <= first_last;
			error_q    <= first_err;
		end else if (cmd.emit_hdr) begin
			out_byte_q <= hdr_byte;
			last_q     <= hdr_last;
			error_q    <= ERR_NONE;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign last       = last_q;
	assign error_code = error_q;

endmodule

`default_nettype wire

// ===== hw/rtl/websocket_masked_frame_encoder_unit.sv =====
// Masked websocket client frame encoder. A start beat (op 0) opens a frame and the
// block streams its header one byte per cycle unless stalled: FIN plus opcode, the
// length in 7, 16 or 64 bit form with the mask bit set, then the four key bytes;
// a close frame adds the masked status 1000. Each payload beat (op 1) gives one
// masked byte. Payload and error beats are taken one per cycle unless stalled; a
// start beat holds off input until its 6, 8, 8 or 14 header bytes (short length,
// close, 16-bit or 64-bit length header) have left the single output register. Output
// stall holds off input while that register is full. No clearing pass after reset.
// depends on wsfe_pkg, wsfe_ctrl, wsfe_dp and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_masked_frame_encoder_unit_defines.svh"

module websocket_masked_frame_encoder_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         op,
	input  wire  [3:0]  frame_type,
	input  wire  [31:0] payload_length,
	input  wire  [31:0] mask_key,
	input  wire  [7:0]  payload_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic [1:0]  error_code
);
	import wsfe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	wsfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// frame state and byte generation
	wsfe_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.op             (op),
		.frame_type     (frame_type),
		.payload_length (payload_length),
		.mask_key       (mask_key),
		.payload_byte   (payload_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.last           (last),
		.error_code     (error_code)
	);

	// checks
	`WSFE_ASSERT_IMPLIES(a_err_is_last, clk, arst_n, out_valid && (error_code != ERR_NONE), last)
	`WSFE_ASSERT_IMPLIES(a_full_blocks_input, clk, arst_n, out_valid && out_stall, in_stall)
	`WSFE_ASSERT_NEXT(a_header_blocks_input, clk, arst_n, in_valid && !in_stall && (op == OP_START) && (frame_type != OPC_CONT) && (frame_type != OPC_PING), in_stall && out_valid)

endmodule

`default_nettype wire
